[sv/mldi_pkg.sv]
// Shared types, widths and helpers for the modal lead / double integrator servo.
// No dependencies; every other file but mldi_ram imports this package.
package mldi_pkg;

	localparam int NUM_MODES = 64;
	localparam int MODE_W    = 6;
	localparam int ADDR_W    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

	localparam int ERR_W     = 24;
	localparam int COEF_W    = 24;
	localparam int ACC_W     = 40;
	localparam int COEF_FRAC = 20;
	localparam int CFG_IDX_W = 3;

	// operand split of the 40-bit lead value for the feedback product
	localparam int LO_W  = COEF_FRAC;
	localparam int HI_W  = ACC_W - COEF_FRAC;
	localparam int PLO_W = COEF_W + LO_W + 1;
	localparam int PHI_W = COEF_W + HI_W;
	localparam int PE_W  = COEF_W + ERR_W;
	localparam int ET_W  = PE_W + 1;
	localparam int SUM_W = 64;
	localparam int RND_W = SUM_W - COEF_FRAC;
	localparam int INC_W = ET_W - COEF_FRAC;

	localparam logic [SUM_W-1:0] HALF_SUM = SUM_W'(1) << (COEF_FRAC - 1);
	localparam logic [ET_W-1:0]  HALF_ET  = ET_W'(1) << (COEF_FRAC - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_TYPE     = 3'd0,
		REG_COEF_FEEDBACK   = 3'd1,
		REG_COEF_INPUT      = 3'd2,
		REG_COEF_PREVIOUS   = 3'd3,
		REG_INTEGRATOR_GAIN = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                     filter_type;
		logic signed [COEF_W-1:0] coef_feedback;
		logic signed [COEF_W-1:0] coef_input;
		logic signed [COEF_W-1:0] coef_previous;
		logic signed [COEF_W-1:0] integrator_gain;
	} cfg_t;

	// one mode's stored filter state, one memory word
	typedef struct packed {
		logic signed [ACC_W-1:0] lead;
		logic signed [ERR_W-1:0] prev;
		logic signed [ACC_W-1:0] fi;
		logic signed [ACC_W-1:0] si;
	} mode_state_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] lead;
		logic signed [ERR_W-1:0] prev;
		logic signed [ACC_W-1:0] fi;
		logic signed [ACC_W-1:0] si;
		logic signed [INC_W-1:0] inc;
		logic                    sat;
	} lead_out_t;

	typedef struct packed {
		logic                    sat;
		logic signed [ACC_W-1:0] val;
	} clip_t;

	// clip a widened sum to the 40-bit accumulator range
	function automatic clip_t sat_acc(input logic [RND_W-1:0] v);
		clip_t r;
		if ((&v[RND_W-1:ACC_W-1]) || !(|v[RND_W-1:ACC_W-1])) begin
			r.sat = 1'b0;
			r.val = v[ACC_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = v[RND_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[sv/mldi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module mldi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/mldi_cfg.sv]
// Configuration register file: filter type and the four Q4.20 coefficients.
// Depends on mldi_pkg.
module mldi_cfg
	import mldi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_type     <= 1'b1;
			cfg_q.coef_feedback   <= '0;
			cfg_q.coef_input      <= '0;
			cfg_q.coef_previous   <= '0;
			cfg_q.integrator_gain <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FILTER_TYPE:     cfg_q.filter_type     <= cfg_data[0];
				REG_COEF_FEEDBACK:   cfg_q.coef_feedback   <= cfg_data;
				REG_COEF_INPUT:      cfg_q.coef_input      <= cfg_data;
				REG_COEF_PREVIOUS:   cfg_q.coef_previous   <= cfg_data;
				REG_INTEGRATOR_GAIN: cfg_q.integrator_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/mldi_lead.sv]
// Lead filter stages s2..s4: split products, partial sums, round and clip.
// Depends on mldi_pkg.
module mldi_lead
	import mldi_pkg::*;
(
	input  logic                    clk,
	input  logic                    adv,
	input  cfg_t                    cfg,
	input  logic signed [ERR_W-1:0] err,
	input  mode_state_t             st,
	output lead_out_t               res
);

	logic signed [COEF_W-1:0] cf, ci, cl, cg;
	logic signed [ACC_W-1:0]  lead_in;
	logic signed [ERR_W-1:0]  prev_in;
	logic signed [LO_W:0]     lead_lo;
	logic signed [HI_W-1:0]   lead_hi;
	logic signed [PLO_W-1:0]  p_lo_d;
	logic signed [PHI_W-1:0]  p_hi_d;
	logic signed [PE_W-1:0]   p_ci_d, p_cl_d, p_gain_d;

	logic signed [PLO_W-1:0]  p_lo_s2;
	logic signed [PHI_W-1:0]  p_hi_s2;
	logic signed [PE_W-1:0]   p_ci_s2, p_cl_s2, p_gain_s2;
	logic signed [ACC_W-1:0]  lead_s2, fi_s2, si_s2;
	logic signed [ERR_W-1:0]  prev_s2;

	logic signed [SUM_W-1:0]  lp_d;
	logic signed [ET_W-1:0]   et_d, g_d;

	logic signed [SUM_W-1:0]  lp_s3;
	logic signed [ET_W-1:0]   et_s3;
	logic signed [INC_W-1:0]  inc_s3;
	logic signed [ACC_W-1:0]  lead_s3, fi_s3, si_s3;
	logic signed [ERR_W-1:0]  prev_s3;

	logic [SUM_W-1:0]         sum_d;
	clip_t                    lead_clp;
	lead_out_t                res_s4;

	assign cf      = cfg.coef_feedback;
	assign ci      = cfg.coef_input;
	assign cl      = cfg.coef_previous;
	assign cg      = cfg.integrator_gain;
	assign lead_in = st.lead;
	assign prev_in = st.prev;
	assign lead_lo = $signed({1'b0, lead_in[LO_W-1:0]});
	assign lead_hi = lead_in[ACC_W-1:LO_W];

	assign p_lo_d   = cf * lead_lo;
	assign p_hi_d   = cf * lead_hi;
	assign p_ci_d   = ci * err;
	assign p_cl_d   = cl * prev_in;
	assign p_gain_d = cg * err;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_lo_s2   <= p_lo_d;
			p_hi_s2   <= p_hi_d;
			p_ci_s2   <= p_ci_d;
			p_cl_s2   <= p_cl_d;
			p_gain_s2 <= p_gain_d;
			lead_s2   <= lead_in;
			// a plain-integrator step keeps the stored previous error
			prev_s2   <= cfg.filter_type ? err : prev_in;
			fi_s2     <= st.fi;
			si_s2     <= st.si;
		end
	end

	assign lp_d = (SUM_W'(p_hi_s2) <<< LO_W) + SUM_W'(p_lo_s2);
	assign et_d = ET_W'(p_ci_s2) - ET_W'(p_cl_s2);
	assign g_d  = ET_W'(p_gain_s2) + HALF_ET;

	always_ff @(posedge clk) begin
		if (adv) begin
			lp_s3   <= lp_d;
			et_s3   <= et_d;
			inc_s3  <= g_d[ET_W-1:COEF_FRAC];
			lead_s3 <= lead_s2;
			prev_s3 <= prev_s2;
			fi_s3   <= fi_s2;
			si_s3   <= si_s2;
		end
	end

	// round half up, then drop the 20 fraction bits
	assign sum_d    = lp_s3 + SUM_W'(et_s3) + HALF_SUM;
	assign lead_clp = sat_acc(sum_d[SUM_W-1:COEF_FRAC]);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4.lead <= cfg.filter_type ? lead_clp.val : lead_s3;
			res_s4.sat  <= cfg.filter_type & lead_clp.sat;
			res_s4.prev <= prev_s3;
			res_s4.fi   <= fi_s3;
			res_s4.si   <= si_s3;
			res_s4.inc  <= inc_s3;
		end
	end

	assign res = res_s4;

endmodule

[sv/mldi_integ.sv]
// Integrator stages: first integrator at s5, second integrator feeding the output.
// Depends on mldi_pkg.
module mldi_integ
	import mldi_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic        filter_type,
	input  lead_out_t   lead,
	output mode_state_t wr,
	output logic        sat
);

	logic signed [ACC_W-1:0] fi_in, lead_in, addend_d;
	logic signed [INC_W-1:0] inc_in;
	clip_t                   fi_clp, si_clp;

	mode_state_t             st_s5;
	logic signed [ACC_W-1:0] addend_s5;
	logic                    sat_s5;
	logic signed [ACC_W-1:0] si_old, addend;

	assign fi_in   = lead.fi;
	assign lead_in = lead.lead;
	assign inc_in  = lead.inc;
	assign fi_clp  = sat_acc(RND_W'(fi_in) + RND_W'(lead_in));
	assign addend_d = filter_type ? fi_clp.val : ACC_W'(inc_in);

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s5.lead <= lead.lead;
			st_s5.prev <= lead.prev;
			st_s5.fi   <= filter_type ? fi_clp.val : fi_in;
			st_s5.si   <= lead.si;
			addend_s5  <= addend_d;
			sat_s5     <= lead.sat | (filter_type & fi_clp.sat);
		end
	end

	assign si_old = st_s5.si;
	assign addend = addend_s5;
	assign si_clp = sat_acc(RND_W'(si_old) + RND_W'(addend));

	always_comb begin
		wr    = st_s5;
		wr.si = si_clp.val;
		sat   = sat_s5 | si_clp.sat;
	end

endmodule

[sv/modal_lead_double_integrator.sv]
// Modal servo filter: per-mode lead filter plus double integrator, or plain integrator.
// Each input beat passes s1..s5, then the output register.
// Throughput: one beat per cycle while modes differ and the output is not stalled; a beat
// whose mode is still in s1..s5 waits until that mode's state is written back.
// Reset clears control, configuration (filter type 1, coefficients 0) and per-mode valid bits;
// an unwritten mode reads as zero state.
module modal_lead_double_integrator
	import mldi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [MODE_W-1:0]       mode_index,
	input  logic signed [ERR_W-1:0] error_sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [MODE_W-1:0]       mode_out,
	output logic signed [ACC_W-1:0] command_value,
	output logic                    saturated,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [COEF_W-1:0]       cfg_data
);

	localparam int STATE_BITS = $bits(mode_state_t);

	cfg_t                    cfg;
	logic                    adv, hazard, acc, in_range;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MODE_W-1:0]       mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic                    rng_s1, rng_s2, rng_s3, rng_s4, rng_s5;
	logic signed [ERR_W-1:0] err_s1;
	logic [NUM_MODES-1:0]    entry_vld_q;
	logic [STATE_BITS-1:0]   ram_rdata;
	mode_state_t             st_s1, wr;
	lead_out_t               lead_res;
	logic                    wr_sat, we;
	logic [ADDR_W-1:0]       waddr;
	logic                    out_valid_q, sat_q;
	logic [MODE_W-1:0]       mode_out_q;
	logic signed [ACC_W-1:0] command_q;

	mldi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = !out_valid_q || out_ready;
	// hold the beat while its mode is still on its way to write-back
	assign hazard   = (vld_s1 && mode_s1 == mode_index) || (vld_s2 && mode_s2 == mode_index)
	               || (vld_s3 && mode_s3 == mode_index) || (vld_s4 && mode_s4 == mode_index)
	               || (vld_s5 && mode_s5 == mode_index);
	assign in_ready = adv && !hazard;
	assign acc      = in_valid && in_ready;
	assign in_range = 32'(mode_index) < NUM_MODES;

	assign we    = adv && vld_s5 && rng_s5;
	assign waddr = ADDR_W'(mode_s5);

	mldi_ram #(
		.WIDTH (STATE_BITS),
		.DEPTH (NUM_MODES)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr),
		.re    (acc),
		.raddr (ADDR_W'(mode_index)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
			entry_vld_q <= '0;
		end else begin
			if (adv) begin
				vld_s1      <= acc;
				vld_s2      <= vld_s1;
				vld_s3      <= vld_s2;
				vld_s4      <= vld_s3;
				vld_s5      <= vld_s4;
				out_valid_q <= vld_s5;
			end
			if (we) begin
				entry_vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_index;
			rng_s1  <= in_range;
			err_s1  <= error_sample;
			mode_s2 <= mode_s1;
			rng_s2  <= rng_s1;
			mode_s3 <= mode_s2;
			rng_s3  <= rng_s2;
			mode_s4 <= mode_s3;
			rng_s4  <= rng_s3;
			mode_s5 <= mode_s4;
			rng_s5  <= rng_s4;
			mode_out_q <= mode_s5;
			command_q  <= rng_s5 ? wr.si : '0;
			sat_q      <= rng_s5 & wr_sat;
		end
	end

	// a mode never written back reads as all-zero state
	assign st_s1 = (rng_s1 && entry_vld_q[ADDR_W'(mode_s1)]) ? mode_state_t'(ram_rdata) : '0;

	mldi_lead u_lead (
		.clk (clk),
		.adv (adv),
		.cfg (cfg),
		.err (err_s1),
		.st  (st_s1),
		.res (lead_res)
	);

	mldi_integ u_integ (
		.clk         (clk),
		.adv         (adv),
		.filter_type (cfg.filter_type),
		.lead        (lead_res),
		.wr          (wr),
		.sat         (wr_sat)
	);

	assign out_valid     = out_valid_q;
	assign mode_out      = mode_out_q;
	assign command_value = command_q;
	assign saturated     = sat_q;

endmodule

[sv/mldi_chk.sv]
// Port-level checks for the modal servo filter, bound to the top level.
// Depends on mldi_pkg and modal_lead_double_integrator.
module mldi_chk
	import mldi_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [MODE_W-1:0]       mode_index,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [MODE_W-1:0]       mode_out,
	input logic signed [ACC_W-1:0] command_value,
	input logic                    saturated
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode_out)
			&& $stable(command_value) && $stable(saturated))
		else $error("result beat changed while stalled");

	// output back-pressure reaches the input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// the same mode cannot follow itself in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (in_valid && mode_index == $past(mode_index)) |-> !in_ready)
		else $error("same-mode beat taken before write-back");

	// with the output free-flowing, an accepted beat comes out with its own mode, in order
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
			##1 out_ready |=> out_valid && mode_out == $past(mode_index, 6))
		else $error("result missing or out of order");

endmodule

bind modal_lead_double_integrator mldi_chk u_chk (.*);
